// ----- hdl/a64rel_pkg.sv -----
`timescale 1ns / 1ps
// a64rel_pkg: shared types, encodings and defaults for the arm64 instruction relocator
// no dependencies

package a64rel_pkg;

    // fixed instruction encodings emitted by the relocator
    localparam logic [31:0] JMP_LDR_X16 = 32'h58000050;
    localparam logic [31:0] ADR_X30_20  = 32'h100000BE;
    localparam logic [31:0] NOP_WORD    = 32'hD503201F;
    localparam logic [31:0] MOVZ_BASE   = 32'hD2800000;
    localparam logic [31:0] MOVK_BASE   = 32'hF2800000;
    localparam logic [31:0] BR_BASE     = 32'hD61F0000;
    localparam logic [31:0] LDR_W_BASE  = 32'hB9400000;
    localparam logic [31:0] LDR_X_BASE  = 32'hF9400000;
    localparam logic [31:0] LDRSW_BASE  = 32'hB9800000;
    localparam logic [31:0] LDR_S_BASE  = 32'hBD400000;
    localparam logic [31:0] LDR_D_BASE  = 32'hFD400000;
    localparam logic [31:0] LDR_Q_BASE  = 32'h3DC00000;
    localparam logic [4:0]  SCRATCH_REG = 5'd16;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // run kinds produced by the front decoder
    typedef logic [2:0] t_kind;
    localparam t_kind K_COPY  = 3'd0; // single word: copied or substituted
    localparam t_kind K_JUMP  = 3'd1; // absolute jump, 4 words
    localparam t_kind K_PJUMP = 3'd2; // prefix word then absolute jump, 5 words
    localparam t_kind K_MOV   = 3'd3; // movz/movk of a 64-bit value, 4 words
    localparam t_kind K_MOVLD = 3'd4; // movz/movk then register load, 5 words
    localparam t_kind K_ABORT = 3'd5; // reserved form, single abort word

    // one classified instruction, handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] pre;  // prefix, copy or load word depending on kind
        logic [63:0] val;  // jump target or materialized value
        logic [4:0]  rd;   // destination register of the movz/movk sequence
    } t_desc;

endpackage

// ----- hdl/a64rel_if.sv -----
`timescale 1ns / 1ps
// a64rel_if: valid/ready channel interfaces for instructions in and words out
// no dependencies

interface a64rel_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    logic [63:0] instr_address;

    modport source (output valid, output instr_word, output instr_address, input ready);
    modport sink   (input valid, input instr_word, input instr_address, output ready);
endinterface

interface a64rel_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        last_word;
    logic        abort_flag;

    modport source (output valid, output out_word, output last_word, output abort_flag,
                    input ready);
    modport sink   (input valid, input out_word, input last_word, input abort_flag,
                    output ready);
endinterface

// ----- hdl/a64rel_front.sv -----
`timescale 1ns / 1ps
// a64rel_front: accepts instructions, classifies them and computes the target address
// depends on a64rel_pkg

module a64rel_front
    import a64rel_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_word,
    input  logic [63:0] i_addr,
    output logic        o_valid,
    input  logic        i_ready,
    output t_desc       o_desc
);

    logic        r_vld;
    t_desc       r_desc;
    t_desc       n_desc;
    logic [63:0] w_base;
    logic [63:0] w_off;
    logic [63:0] w_sum;
    logic [4:0]  w_rt;
    logic        w_load;

    assign w_rt    = i_word[4:0];
    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_desc  = r_desc;
    assign w_load  = i_valid && o_ready;

    // one shared adder for all pc-relative targets
    always_comb begin
        w_base = i_addr;
        if (i_word[31:26] == 6'b000101 || i_word[31:26] == 6'b100101) begin
            w_off = {{36{i_word[25]}}, i_word[25:0], 2'b00};
        end else if (i_word[30:25] == 6'b011011) begin
            w_off = {{48{i_word[18]}}, i_word[18:5], 2'b00};
        end else if (i_word[28:24] == 5'b10000 && !i_word[31]) begin
            w_off = {{43{i_word[23]}}, i_word[23:5], i_word[30:29]};
        end else if (i_word[28:24] == 5'b10000) begin
            w_base = {i_addr[63:12], 12'h000};
            w_off  = {{31{i_word[23]}}, i_word[23:5], i_word[30:29], 12'h000};
        end else begin
            w_off = {{43{i_word[23]}}, i_word[23:5], 2'b00};
        end
        w_sum = w_base + w_off;
    end

    // classification, in priority order
    always_comb begin
        n_desc.kind = K_COPY;
        n_desc.pre  = i_word;
        n_desc.val  = w_sum;
        n_desc.rd   = w_rt;
        if (i_word[31:26] == 6'b000101) begin
            n_desc.kind = K_JUMP;
        end else if (i_word[31:26] == 6'b100101) begin
            n_desc.kind = K_PJUMP;
            n_desc.pre  = ADR_X30_20;
        end else if (i_word[31:24] == 8'h54 && !i_word[4]) begin
            n_desc.kind = K_PJUMP;
            n_desc.pre  = 32'h540000A0 | {28'h0000000, i_word[3:1], ~i_word[0]};
        end else if (i_word[30:25] == 6'b011010) begin
            n_desc.kind = K_PJUMP;
            n_desc.pre  = {i_word[31], 6'b011010, ~i_word[24], 19'd5, w_rt};
        end else if (i_word[30:25] == 6'b011011) begin
            n_desc.kind = K_PJUMP;
            n_desc.pre  = {i_word[31], 6'b011011, ~i_word[24], i_word[23:19], 14'd5, w_rt};
        end else if (i_word[28:24] == 5'b10000) begin
            n_desc.kind = K_MOV;
        end else if (!i_word[31] && i_word[29:24] == 6'b011000) begin
            n_desc.kind = K_MOVLD;
            n_desc.pre  = (i_word[30] ? LDR_X_BASE : LDR_W_BASE) | {22'h0, w_rt, w_rt};
        end else if (i_word[31:24] == 8'h98) begin
            n_desc.kind = K_MOVLD;
            n_desc.pre  = LDRSW_BASE | {22'h0, w_rt, w_rt};
        end else if (i_word[29:24] == 6'b011100) begin
            n_desc.rd = SCRATCH_REG;
            unique case (i_word[31:30])
                2'd0:    begin n_desc.kind = K_MOVLD; n_desc.pre = LDR_S_BASE; end
                2'd1:    begin n_desc.kind = K_MOVLD; n_desc.pre = LDR_D_BASE; end
                2'd2:    begin n_desc.kind = K_MOVLD; n_desc.pre = LDR_Q_BASE; end
                default: begin n_desc.kind = K_ABORT; n_desc.pre = 32'h0; end
            endcase
            if (n_desc.kind == K_MOVLD) begin
                n_desc.pre = n_desc.pre | {22'h0, SCRATCH_REG, w_rt};
            end
        end else if (i_word[31:24] == 8'hD8) begin
            n_desc.pre = NOP_WORD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_desc <= n_desc;
        end
    end

endmodule

// ----- hdl/a64rel_queue.sv -----
`timescale 1ns / 1ps
// a64rel_queue: small descriptor queue between front and back
// depends on a64rel_pkg

module a64rel_queue
    import a64rel_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_desc i_desc,
    output logic  o_valid,
    input  logic  i_pop,
    output t_desc o_desc
);

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_desc         r_mem [P_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

// ----- hdl/a64rel_back.sv -----
`timescale 1ns / 1ps
// a64rel_back: walks one descriptor word by word into the output register
// depends on a64rel_pkg

module a64rel_back
    import a64rel_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_desc       i_desc,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word,
    output logic        o_last,
    output logic        o_abort
);

    logic [2:0]  r_idx;
    logic        r_ovld;
    logic [31:0] r_word;
    logic        r_last;
    logic        r_abort;
    logic [2:0]  w_sub;
    logic [2:0]  w_last_idx;
    logic        w_is_last;
    logic [31:0] w_word;
    logic        w_load;
    logic        w_take;

    function automatic logic [31:0] mov_word(input logic [1:0] m, input logic [63:0] v,
                                             input logic [4:0] rd);
        logic [15:0] chunk;
        logic [31:0] base;
        chunk = v[{m, 4'b0000} +: 16];
        base  = (m == 2'd0) ? MOVZ_BASE : MOVK_BASE;
        return base | {9'h000, m, chunk, rd};
    endfunction

    function automatic logic [31:0] jump_word(input logic [1:0] j, input logic [63:0] v);
        logic [31:0] res;
        unique case (j)
            2'd0:    res = JMP_LDR_X16;
            2'd1:    res = BR_BASE | {22'h0, SCRATCH_REG, 5'd0};
            2'd2:    res = v[31:0];
            default: res = v[63:32];
        endcase
        return res;
    endfunction

    always_comb begin
        unique case (i_desc.kind) inside
            K_JUMP, K_MOV:    w_last_idx = 3'd3;
            K_PJUMP, K_MOVLD: w_last_idx = 3'd4;
            default:          w_last_idx = 3'd0;
        endcase
    end

    assign w_sub     = (i_desc.kind == K_PJUMP) ? r_idx - 3'd1 : r_idx;
    assign w_is_last = (r_idx == w_last_idx);

    always_comb begin
        unique case (i_desc.kind) inside
            K_JUMP, K_PJUMP: begin
                if (i_desc.kind == K_PJUMP && r_idx == 3'd0) begin
                    w_word = i_desc.pre;
                end else begin
                    w_word = jump_word(w_sub[1:0], i_desc.val);
                end
            end
            K_MOV:   w_word = mov_word(r_idx[1:0], i_desc.val, i_desc.rd);
            K_MOVLD: w_word = (r_idx == 3'd4) ? i_desc.pre
                                              : mov_word(r_idx[1:0], i_desc.val, i_desc.rd);
            K_ABORT: w_word = 32'h0;
            default: w_word = i_desc.pre;
        endcase
    end

    assign w_load  = !r_ovld || i_ready;
    assign w_take  = w_load && i_valid;
    assign o_pop   = w_take && w_is_last;
    assign o_valid = r_ovld;
    assign o_word  = r_word;
    assign o_last  = r_last;
    assign o_abort = r_abort;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_idx  <= 3'd0;
        end else if (w_take) begin
            r_ovld <= 1'b1;
            r_idx  <= w_is_last ? 3'd0 : r_idx + 3'd1;
        end else if (w_load) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_word  <= w_word;
            r_last  <= w_is_last;
            r_abort <= (i_desc.kind == K_ABORT);
        end
    end

endmodule

// ----- hdl/arm64_instruction_relocator_core.sv -----
`timescale 1ns / 1ps
// arm64_instruction_relocator_core: top level of the arm64 instruction relocator
// depends on a64rel_pkg, a64rel_if, a64rel_front, a64rel_queue, a64rel_back
//
//  channel  dir  modport  payload                               per transaction
//  i_in     in   sink     instr_word[31:0], instr_address[63:0] one instruction
//  o_out    out  source   out_word[31:0], last_word, abort_flag one emitted word
//
// an instruction yields 1, 4 or 5 output transactions; the back end emits one word per
// cycle while the output is ready; the first word passes through the front register,
// the queue and the output register
// synchronous active-low reset clears all control state; the queue storage needs no clearing
// input and output stall independently: the queue absorbs back-pressure until full

module arm64_instruction_relocator_core
    import a64rel_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    a64rel_in_if.sink   i_in,
    a64rel_out_if.source o_out
);

    // front to queue
    logic  w_f_valid;
    logic  w_f_ready;
    logic  w_in_ready;
    t_desc w_f_desc;

    // queue to back
    logic  w_q_valid;
    logic  w_q_pop;
    t_desc w_q_desc;

    // back to output port
    logic        w_o_valid;
    logic [31:0] w_o_word;
    logic        w_o_last;
    logic        w_o_abort;

    assign i_in.ready = w_in_ready;

    // decode and target address computation, one instruction per cycle while the queue accepts
    a64rel_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (w_in_ready),
        .i_word  (i_in.instr_word),
        .i_addr  (i_in.instr_address),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_desc  (w_f_desc)
    );

    // decouples decode from word emission
    a64rel_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_desc  (w_f_desc),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_desc  (w_q_desc)
    );

    // word sequencer; head descriptor pops on its last word
    a64rel_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_desc  (w_q_desc),
        .o_pop   (w_q_pop),
        .o_valid (w_o_valid),
        .i_ready (o_out.ready),
        .o_word  (w_o_word),
        .o_last  (w_o_last),
        .o_abort (w_o_abort)
    );

    assign o_out.valid      = w_o_valid;
    assign o_out.out_word   = w_o_word;
    assign o_out.last_word  = w_o_last;
    assign o_out.abort_flag = w_o_abort;

endmodule

// ----- hdl/a64rel_checker.sv -----
`timescale 1ns / 1ps
// a64rel_port_checker: port-level assertions on the relocator output stream
// bound to arm64_instruction_relocator_core

module a64rel_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [31:0] i_word,
    input  logic        i_last,
    input  logic        i_abort
);

    // words already delivered in the current run
    logic [2:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_valid && i_ready) begin
            r_cnt <= i_last ? 3'd0 : r_cnt + 3'd1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_word) && $stable(i_last)
                                && $stable(i_abort))
        else $error("output changed while stalled");

    a_abort_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_abort |-> i_last && i_word == 32'h0)
        else $error("abort word malformed");

    a_abort_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_cnt != 3'd0 |-> !i_abort)
        else $error("abort inside a run");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_cnt == 3'd4 |-> i_last)
        else $error("run longer than five words");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid right after reset");

endmodule

bind arm64_instruction_relocator_core a64rel_port_checker u_a64rel_port_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_word  (o_out.out_word),
    .i_last  (o_out.last_word),
    .i_abort (o_out.abort_flag)
);
